@@ rtl/free_index_stack_allocator_defines.svh @@
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef FREE_INDEX_STACK_ALLOCATOR_DEFINES_SVH
`define FREE_INDEX_STACK_ALLOCATOR_DEFINES_SVH

// Check that is disabled while reset is high.
`define FISA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Check that also holds during reset.
`define FISA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

@@ rtl/fisa_pkg.sv @@
// Shared widths, codes and control types of the free index stack allocator.
// No dependencies; compile first after the defines header.
package fisa_pkg;

   localparam int unsigned IDX_W      = 10;
   localparam int unsigned OFF_W      = 26;
   localparam int unsigned HEAD_W     = 11;
   localparam int unsigned SLOT_W     = 17;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 17;

   localparam int unsigned POOL_DEPTH_DEFAULT = 1024;

   localparam logic [HEAD_W-1:0] POOL_COUNT_RESET = 11'd1024;
   localparam logic [SLOT_W-1:0] SLOT_BYTES_RESET = 17'd64;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_ACCESS  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POOL_COUNT = 1'b0,
      CSR_SLOT_BYTES = 1'b1
   } csr_idx_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request payload
      logic exec;      // perform the latched operation, load result
      logic sweep_wr;  // write one identity entry
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      mode_type op;
      logic     rsp_free;
      logic     sweep_done;
   } ctrl_stat_type;

endpackage

@@ rtl/fisa_req_if.sv @@
// Request channel of the allocator: valid/ready plus mode and slot index.
// Depends on fisa_pkg.
interface fisa_req_if;
   logic                         valid;
   logic                         ready;
   logic [fisa_pkg::MODE_W-1:0]  mode;
   logic [fisa_pkg::IDX_W-1:0]   slot_index;

   modport source (output valid, output mode, output slot_index, input ready);
   modport sink   (input valid, input mode, input slot_index, output ready);
endinterface

@@ rtl/fisa_rsp_if.sv @@
// Response channel of the allocator: valid/ready plus result fields.
// Depends on fisa_pkg.
interface fisa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fisa_pkg::IDX_W-1:0]    granted_index;
   logic [fisa_pkg::OFF_W-1:0]    byte_offset;
   logic [fisa_pkg::STATUS_W-1:0] status;
   logic [fisa_pkg::HEAD_W-1:0]   in_use;

   modport source (output valid, output granted_index, output byte_offset,
                   output status, output in_use, input ready);
   modport sink   (input valid, input granted_index, input byte_offset,
                   input status, input in_use, output ready);
endinterface

@@ rtl/fisa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fisa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/fisa_ctrl.sv @@
// Allocator controller: clearing sweep, request accept and execute sequencing.
// Depends on fisa_pkg.
module fisa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fisa_pkg::ctrl_stat_type stat,
   output fisa_pkg::ctrl_cmd_type  cmd
);
   import fisa_pkg::*;

   typedef enum logic [2:0] {
      S_SWEEP = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.exec     = 1'b0;
      cmd.sweep_wr = 1'b0;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sweep_wr = 1'b1;
            if (stat.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the output register can take the result
            if (stat.rsp_free) begin
               cmd.exec = 1'b1;
               state_in = (stat.op == MODE_RELEASE) ? S_SWEEP : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/fisa_dpath.sv @@
// Allocator datapath: config registers, stack head, free-index RAM, result register.
// Depends on fisa_pkg and fisa_ram.
module fisa_dpath #(
   parameter int unsigned POOL_DEPTH = fisa_pkg::POOL_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [fisa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fisa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [fisa_pkg::MODE_W-1:0]      req_mode,
   input  logic [fisa_pkg::IDX_W-1:0]       req_slot_index,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [fisa_pkg::IDX_W-1:0]       rsp_granted_index,
   output logic [fisa_pkg::OFF_W-1:0]       rsp_byte_offset,
   output logic [fisa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [fisa_pkg::HEAD_W-1:0]      rsp_in_use,
   input  fisa_pkg::ctrl_cmd_type           cmd,
   output fisa_pkg::ctrl_stat_type          stat
);
   import fisa_pkg::*;

   localparam int unsigned AW       = $clog2(POOL_DEPTH);
   localparam int unsigned HeadMax  = (1 << HEAD_W) - 1;
   localparam int unsigned DepthCap = (POOL_DEPTH > HeadMax) ? HeadMax : POOL_DEPTH;
   localparam logic [AW-1:0] SweepLast = AW'(POOL_DEPTH - 1);

   logic [HEAD_W-1:0] pool_count_ff, pool_count_in;
   logic [SLOT_W-1:0] slot_bytes_ff, slot_bytes_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [AW-1:0]     sweep_cnt_ff, sweep_cnt_in;
   mode_type          op_ff, op_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  granted_ff, granted_in;
   logic [OFF_W-1:0]  offset_ff, offset_in;
   status_type        status_ff, status_in;
   logic [HEAD_W-1:0] in_use_ff, in_use_in;

   logic [HEAD_W-1:0]       count_eff;
   logic [IDX_W+SLOT_W-1:0] product;
   logic [HEAD_W-1:0]       head_dec;
   logic                    free_wr;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [IDX_W-1:0]        ram_wdata;
   logic [IDX_W-1:0]        ram_rdata;

   // configuration
   always_comb begin
      pool_count_in = pool_count_ff;
      slot_bytes_in = slot_bytes_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_POOL_COUNT: pool_count_in = csr_wdata[HEAD_W-1:0];
            CSR_SLOT_BYTES: slot_bytes_in = csr_wdata[SLOT_W-1:0];
         endcase
      end
   end

   assign count_eff = (pool_count_ff < HEAD_W'(DepthCap)) ? pool_count_ff
                                                           : HEAD_W'(DepthCap);
   assign product   = {{SLOT_W{1'b0}}, idx_ff} * {{IDX_W{1'b0}}, slot_bytes_ff};
   assign head_dec  = head_ff - HEAD_W'(1);

   assign op_in  = cmd.capture ? mode_type'(req_mode) : op_ff;
   assign idx_in = cmd.capture ? req_slot_index : idx_ff;

   // execute; RAM data holds the entry at the head, read on the accept edge
   always_comb begin
      head_in    = head_ff;
      granted_in = granted_ff;
      offset_in  = offset_ff;
      status_in  = status_ff;
      in_use_in  = in_use_ff;
      free_wr    = 1'b0;
      if (cmd.exec) begin
         granted_in = '0;
         offset_in  = '0;
         status_in  = ST_OK;
         unique case (op_ff)
            MODE_ALLOC: begin
               if (head_ff < count_eff) begin
                  granted_in = ram_rdata;
                  head_in    = head_ff + HEAD_W'(1);
               end else begin
                  status_in = ST_EMPTY;
               end
            end
            MODE_FREE: begin
               if (head_ff == '0) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  head_in = head_dec;
                  free_wr = 1'b1;
               end
            end
            MODE_RELEASE: begin
               head_in = '0;
            end
            MODE_ACCESS: begin
               if ({1'b0, idx_ff} < count_eff) begin
                  offset_in = product[OFF_W-1:0];
               end else begin
                  status_in = ST_BAD_INDEX;
               end
            end
         endcase
         in_use_in = head_in;
      end
   end

   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // identity refill sweep over the whole stack
   always_comb begin
      sweep_cnt_in = sweep_cnt_ff;
      if (cmd.exec && op_ff == MODE_RELEASE) begin
         sweep_cnt_in = '0;
      end else if (cmd.sweep_wr) begin
         sweep_cnt_in = (sweep_cnt_ff == SweepLast) ? '0 : sweep_cnt_ff + AW'(1);
      end
   end

   assign ram_we    = free_wr || cmd.sweep_wr;
   assign ram_waddr = cmd.sweep_wr ? sweep_cnt_ff : AW'(head_dec);
   assign ram_wdata = cmd.sweep_wr ? IDX_W'(sweep_cnt_ff) : idx_ff;

   fisa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (POOL_DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (AW'(head_ff)),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_count_ff <= POOL_COUNT_RESET;
         slot_bytes_ff <= SLOT_BYTES_RESET;
         head_ff       <= '0;
         sweep_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pool_count_ff <= pool_count_in;
         slot_bytes_ff <= slot_bytes_in;
         head_ff       <= head_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      granted_ff <= granted_in;
      offset_ff  <= offset_in;
      status_ff  <= status_in;
      in_use_ff  <= in_use_in;
   end

   assign stat.op         = op_ff;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign stat.sweep_done = (sweep_cnt_ff == SweepLast);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_byte_offset   = offset_ff;
   assign rsp_status        = status_ff;
   assign rsp_in_use        = in_use_ff;

endmodule

@@ rtl/free_index_stack_allocator.sv @@
// Free index stack allocator: pops and pushes slot indices on a RAM-backed
// free stack and turns an index into a byte offset. Allocate, free and access
// are each accepted, then executed on the stack RAM's registered read port;
// a request may arrive while the previous response still waits. Release-all
// answers likewise, then rewrites the identity stack, one entry a cycle over
// all POOL_DEPTH entries, before the next request is taken. After reset the
// same clearing pass runs with req_chan.ready low; csr writes are taken at
// any time.
// Depends on fisa_pkg, fisa_req_if, fisa_rsp_if, fisa_ctrl, fisa_dpath.
module free_index_stack_allocator #(
   parameter int unsigned POOL_DEPTH = fisa_pkg::POOL_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [fisa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fisa_pkg::CSR_DATA_W-1:0] csr_wdata,
   fisa_req_if.sink                        req_chan,
   fisa_rsp_if.source                      rsp_chan
);
   import fisa_pkg::*;
   `include "free_index_stack_allocator_defines.svh"

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;
   logic          req_ready;

   fisa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fisa_dpath #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_mode          (req_chan.mode),
      .req_slot_index    (req_chan.slot_index),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_granted_index (rsp_chan.granted_index),
      .rsp_byte_offset   (rsp_chan.byte_offset),
      .rsp_status        (rsp_chan.status),
      .rsp_in_use        (rsp_chan.in_use),
      .cmd               (cmd),
      .stat              (stat)
   );

   assign req_chan.ready = req_ready;

   // one request in flight at a time
   `FISA_ASSERT(a_one_in_flight, clock, reset, (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
   // stack sweep and execute never share the RAM write port
   `FISA_ASSERT_ALWAYS(a_sweep_excl, clock, !(cmd.exec && cmd.sweep_wr))
   // clearing pass after reset blocks requests
   `FISA_ASSERT_ALWAYS(a_reset_sweep, clock, $past(reset) |-> !req_chan.ready)
   // a response appears only from an execute step
   `FISA_ASSERT(a_rsp_source, clock, reset, $rose(rsp_chan.valid) |-> $past(cmd.exec))

endmodule
